// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/bta_pkg.sv =====
// Types, codes and constants of the bakery ticket arbiter.
`timescale 1ns / 1ps

package bta_pkg;

   // Default sizing of the arbiter.
   localparam int MAX_CLIENTS_DEF = 16;
   localparam int TICKET_BITS_DEF = 16;

   // Fixed widths of the port fields, and the reset value of the active count.
   localparam int ACTIVE_W     = 5;
   localparam int CLIENT_W     = 4;
   localparam int ISSUED_W     = 16;
   localparam int ACTIVE_RESET = 16;

   // Operation carried by a request word.
   typedef enum logic {
      MODE_TAKE    = 1'b0,
      MODE_RELEASE = 1'b1
   } bta_mode_type;

   // Completion status returned with every response word.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_RANGE     = 2'd2
   } bta_status_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_SCAN,
      S_DONE
   } bta_state_type;

   // Control from the sequencer to the running-minimum unit.
   typedef struct packed {
      logic clear;
      logic sample;
   } bta_scan_ctl_type;

endpackage

// ===== hw/rtl/bta_if.sv =====
// Request and response channel interfaces of the arbiter.
`timescale 1ns / 1ps

interface bta_req_if import bta_pkg::*; ();
   logic                valid;
   logic                ready;
   bta_mode_type        mode;
   logic [CLIENT_W-1:0] client;

   modport source (output valid, output mode, output client, input ready);
   modport sink (input valid, input mode, input client, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ISSUED_W-1:0] issued_ticket;
   logic                grant_valid;
   logic [CLIENT_W-1:0] granted_client;
   bta_status_type      status;

   modport source (output valid, output issued_ticket, output grant_valid,
                   output granted_client, output status, input ready);
   modport sink (input valid, input issued_ticket, input grant_valid,
                 input granted_client, input status, output ready);
endinterface

// ===== hw/rtl/bta_min_scan.sv =====
// Running-minimum unit that finds the smallest nonzero ticket over a scan.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bta_min_scan import bta_pkg::*; #(
   parameter int TICKET_BITS = TICKET_BITS_DEF,
   parameter int IDX_W       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bta_scan_ctl_type       ctl,
   input  logic [TICKET_BITS-1:0] ticket,
   input  logic [IDX_W-1:0]       idx,
   output logic                   found,
   output logic [IDX_W-1:0]       best_idx
);

   logic                   found_ff;
   logic                   found_in;
   logic [TICKET_BITS-1:0] best_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic                   take;

   // A strictly smaller ticket replaces the best, so the lower index keeps a tie.
   assign take = ctl.sample && (ticket != '0) && (!found_ff || (ticket < best_ff));

   always_comb begin
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // Best ticket and its owner need no reset: found qualifies them.
   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= ticket;
         best_idx_ff <= idx;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;

   `ASSERT_IMPL(a_clear_not_sample, clock, reset, ctl.clear, !ctl.sample)
   `ASSERT_NEXT(a_found_sticky, clock, reset, found_ff && !ctl.clear, found_ff)

endmodule

// ===== hw/rtl/bakery_ticket_arbiter.sv =====
// Bakery ticket arbiter: issues and releases tickets and reports the grant holder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each request word either takes a fresh ticket for a client (the next value
// of a counter that only rises) or releases the client's ticket, and produces
// one response word with the issued ticket, the status and the current grant
// holder: the active client with the smallest nonzero ticket, the lower index
// winning a tie. Tickets are held in a single-port memory with a registered
// read; valid bits make the memory read as zero after reset, so no clearing
// pass is needed. After acceptance an item updates its entry, then reads the
// memory once per active client and compares the last entry read, then loads
// the response register once no earlier response is still waiting. The next
// request word is accepted as soon as the response is loaded, even while that
// response still waits to be taken.
module bakery_ticket_arbiter import bta_pkg::*; #(
   parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
   parameter int TICKET_BITS = TICKET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   bta_req_if.sink             req_chan,
   bta_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [ACTIVE_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_CLIENTS);
   localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
   localparam int CMP_W  = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
   localparam logic [CMP_W-1:0]       MAX_C      = CMP_W'(MAX_CLIENTS);
   localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

   // Sequencer and item registers.
   bta_state_type        state_ff;
   bta_state_type        state_in;
   bta_mode_type         item_mode_ff;
   logic [CLIENT_W-1:0]  item_client_ff;
   logic [ACTIVE_W-1:0]  active_ff;
   logic [TICKET_BITS-1:0] last_ticket_ff;
   logic [CNT_W-1:0]     rd_cnt_ff;
   logic                 rd_vld_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;
   bta_status_type       res_status_ff;
   logic [ISSUED_W-1:0]  res_issued_ff;

   // Response register.
   logic                 rsp_valid_ff;
   logic [ISSUED_W-1:0]  rsp_issued_ff;
   logic                 rsp_grant_ff;
   logic [CLIENT_W-1:0]  rsp_client_ff;
   bta_status_type       rsp_status_ff;

   // Ticket memory with per-entry valid bits.
   logic [TICKET_BITS-1:0] mem [MAX_CLIENTS];
   logic [MAX_CLIENTS-1:0] ent_vld_ff;
   logic [TICKET_BITS-1:0] rdata_ff;
   logic                   rd_ent_vld_ff;

   // Combinational control.
   logic                   req_ready;
   logic                   take_item;
   logic                   do_update;
   logic                   rd_en;
   logic                   load_rsp;
   logic [CMP_W-1:0]       act_ext;
   logic [CMP_W-1:0]       eff_cmp;
   logic [CNT_W-1:0]       eff_cnt;
   logic [CMP_W-1:0]       who_cmp;
   logic [TICKET_BITS-1:0] next_ticket;
   bta_status_type         upd_status;
   logic                   upd_write;
   logic                   upd_issue;
   logic [TICKET_BITS-1:0] upd_wdata;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [TICKET_BITS-1:0] scan_ticket;
   bta_scan_ctl_type       scan_ctl;
   logic                   scan_found;
   logic [ADDR_W-1:0]      scan_idx;

   // Active client count saturated to 1..MAX_CLIENTS.
   assign act_ext = CMP_W'(active_ff);
   assign eff_cmp = (act_ext == '0) ? CMP_W'(1) : ((act_ext > MAX_C) ? MAX_C : act_ext);
   assign eff_cnt = CNT_W'(eff_cmp);
   assign who_cmp = CMP_W'(item_client_ff);

   // Sequencer: accept, update one entry, scan the memory, load the response.
   always_comb begin
      state_in  = state_ff;
      take_item = 1'b0;
      do_update = 1'b0;
      rd_en     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               take_item = 1'b1;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            do_update = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (rd_cnt_ff < eff_cnt) begin
               rd_en = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign req_chan.ready = req_ready;

   // Decide the outcome of the item; the range check takes priority.
   assign next_ticket = last_ticket_ff + TICKET_BITS'(1);

   always_comb begin
      upd_status = ST_OK;
      upd_write  = 1'b0;
      upd_issue  = 1'b0;
      upd_wdata  = '0;
      if (item_mode_ff == MODE_TAKE) begin
         priority if (who_cmp >= eff_cmp) begin
            upd_status = ST_RANGE;
         end else if (last_ticket_ff == TICKET_TOP) begin
            upd_status = ST_EXHAUSTED;
         end else begin
            upd_write = 1'b1;
            upd_issue = 1'b1;
            upd_wdata = next_ticket;
         end
      end else begin
         if (who_cmp >= MAX_C) begin
            upd_status = ST_RANGE;
         end else begin
            upd_write = 1'b1;
         end
      end
   end

   // Writes happen only in the update cycle and reads only while scanning,
   // so an entry is never read and written in the same cycle.
   assign mem_we    = do_update && upd_write;
   assign mem_waddr = ADDR_W'(item_client_ff);
   assign rd_addr   = rd_cnt_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= upd_wdata;
      end
      if (rd_en) begin
         rdata_ff      <= mem[rd_addr];
         rd_ent_vld_ff <= ent_vld_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as no ticket.
   assign scan_ticket = rd_ent_vld_ff ? rdata_ff : '0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         active_ff      <= ACTIVE_W'(ACTIVE_RESET);
         last_ticket_ff <= '0;
         ent_vld_ff     <= '0;
         rd_cnt_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (do_update && upd_issue) begin
            last_ticket_ff <= next_ticket;
         end
         if (mem_we) begin
            ent_vld_ff[mem_waddr] <= 1'b1;
         end
         if (do_update) begin
            rd_cnt_ff <= '0;
         end else if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_item) begin
         item_mode_ff   <= req_chan.mode;
         item_client_ff <= req_chan.client;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
      if (do_update) begin
         res_status_ff <= upd_status;
         res_issued_ff <= upd_issue ? ISSUED_W'(next_ticket) : '0;
      end
      if (load_rsp) begin
         rsp_issued_ff <= res_issued_ff;
         rsp_status_ff <= res_status_ff;
         rsp_grant_ff  <= scan_found;
         rsp_client_ff <= scan_found ? CLIENT_W'(scan_idx) : '0;
      end
   end

   // Running minimum over the scanned entries.
   assign scan_ctl.clear  = do_update;
   assign scan_ctl.sample = rd_vld_ff;

   bta_min_scan #(
      .TICKET_BITS (TICKET_BITS),
      .IDX_W       (ADDR_W)
   ) u_min_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .ticket   (scan_ticket),
      .idx      (rd_idx_ff),
      .found    (scan_found),
      .best_idx (scan_idx)
   );

   // Response channel.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.issued_ticket  = rsp_issued_ff;
   assign rsp_chan.grant_valid    = rsp_grant_ff;
   assign rsp_chan.granted_client = rsp_client_ff;
   assign rsp_chan.status         = rsp_status_ff;

   `ASSERT_NEXT(a_accept_to_update, clock, reset, req_chan.valid && req_ready, state_ff == S_UPDATE)
   `ASSERT_IMPL(a_no_rw_overlap, clock, reset, mem_we, !rd_en)
   `ASSERT_IMPL(a_issue_means_ok, clock, reset, rsp_valid_ff && (rsp_issued_ff != '0), rsp_status_ff == ST_OK)
   `ASSERT_IMPL(a_no_grant_zero_idx, clock, reset, rsp_valid_ff && !rsp_grant_ff, rsp_client_ff == '0)

endmodule
